>>> rtl/rch_pkg.sv
// Shared types and constants for the reference-counted compacting heap.
// Used by every module under rtl except rch_ram; depends on nothing.
package rch_pkg;
  localparam int MEMORY_BYTES = 65536;
  localparam int MAX_ENTRIES  = 32;
  localparam int IDX_W        = $clog2(MAX_ENTRIES);
  localparam int CNT_W        = $clog2(MAX_ENTRIES + 1);
  localparam int TBL_DEPTH    = 2 ** IDX_W;
  localparam int OFS_W        = 17;
  localparam int RC_W         = 16;

  localparam logic KIND_COPY   = 1'b0;
  localparam logic KIND_ANSWER = 1'b1;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_RETRIEVE = 2'd1,
    OP_ADD      = 2'd2,
    OP_DROP     = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t          opcode;
    logic [OFS_W-1:0] size;
    logic [31:0]      ref_req;
  } item_t;

  typedef struct packed {
    logic             kind;
    logic [31:0]      ref_out;
    logic             found;
    logic [OFS_W-1:0] addr;
    logic [OFS_W-1:0] src_addr;
    logic [OFS_W-1:0] length;
    logic             buffer_sel;
    logic             last;
  } result_t;

  typedef struct packed {
    logic [31:0]      eref;
    logic [OFS_W-1:0] bytes;
    logic [OFS_W-1:0] offset;
    logic [RC_W-1:0]  count;
  } entry_t;

  typedef struct packed {
    item_t item;
    logic  is_insert;
  } cmd_t;
endpackage

>>> rtl/rch_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/rch_front.sv
// Front end: accepts requests, tags inserts, and queues them for the back end.
// Depends on rch_pkg.
module rch_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  rch_pkg::item_t item,
  output logic          busy,
  output rch_pkg::cmd_t cmd,
  output logic          cmd_valid,
  input  logic          pop
);
  rch_pkg::cmd_t slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;
  logic       push;

  assign busy      = (fill == 2'd2);
  assign push      = start && !busy;
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr].item      <= item;
      slots[wptr].is_insert <= (item.opcode == rch_pkg::OP_INSERT);
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end
endmodule

>>> rtl/rch_back.sv
// Back end: walks the descriptor table for lookups and compaction, then answers.
// Depends on rch_pkg and rch_ram.
module rch_back (
  input  logic            clk,
  input  logic            rst,
  input  rch_pkg::cmd_t   cmd,
  input  logic            cmd_valid,
  output logic            pop,
  output logic            res_valid,
  output rch_pkg::result_t res
);
  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_SCAN_LK = 4'b0010,
    S_SCAN_CP = 4'b0100,
    S_INSERT  = 4'b1000
  } state_t;

  localparam logic [rch_pkg::OFS_W:0] MEM_SIZE = (rch_pkg::OFS_W+1)'(rch_pkg::MEMORY_BYTES);
  localparam logic [rch_pkg::CNT_W-1:0] MAX_CNT = rch_pkg::CNT_W'(rch_pkg::MAX_ENTRIES);

  state_t                      state;
  rch_pkg::cmd_t               cur;
  logic [rch_pkg::CNT_W-1:0]   used;
  logic [rch_pkg::OFS_W-1:0]   free_ofs;
  logic                        half;
  logic [31:0]                 next_ref;
  logic [rch_pkg::CNT_W-1:0]   i;
  logic                        pv;
  logic [rch_pkg::IDX_W-1:0]   pidx;
  logic [rch_pkg::CNT_W-1:0]   keep;
  logic [rch_pkg::OFS_W-1:0]   dst;

  logic                        we;
  logic [rch_pkg::IDX_W-1:0]   waddr;
  rch_pkg::entry_t             wdata;
  rch_pkg::entry_t             rdata;
  logic [rch_pkg::OFS_W:0]     room;
  logic                        fits_new;
  logic                        fits_cur;
  logic                        match;
  logic                        more;

  rch_ram #(.WIDTH($bits(rch_pkg::entry_t)), .DEPTH(rch_pkg::TBL_DEPTH)) u_tbl (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(i[rch_pkg::IDX_W-1:0]),
    .rdata(rdata)
  );

  assign room     = MEM_SIZE - {1'b0, free_ofs};
  assign fits_new = (room >= {1'b0, cmd.item.size}) && (used < MAX_CNT);
  assign fits_cur = (room >= {1'b0, cur.item.size}) && (used < MAX_CNT);
  assign match    = pv && (rdata.eref == cur.item.ref_req);
  assign more     = (i < used);
  assign pop      = (state == S_IDLE) && cmd_valid;

  always_comb begin
    we    = 1'b0;
    waddr = pidx;
    wdata = rdata;
    unique case (state)
      S_SCAN_LK: begin
        if (match) begin
          we = 1'b1;
          if (cur.item.opcode == rch_pkg::OP_ADD && rdata.count != '1) begin
            wdata.count = rdata.count + 1'b1;
          end else if (cur.item.opcode == rch_pkg::OP_DROP && rdata.count != '0) begin
            wdata.count = rdata.count - 1'b1;
          end
        end
      end
      S_SCAN_CP: begin
        if (pv && rdata.count != '0) begin
          we           = 1'b1;
          waddr        = keep[rch_pkg::IDX_W-1:0];
          wdata.offset = dst;
        end
      end
      S_INSERT: begin
        we    = fits_cur;
        waddr = used[rch_pkg::IDX_W-1:0];
        wdata = '{eref: next_ref, bytes: cur.item.size, offset: free_ofs,
                  count: rch_pkg::RC_W'(1)};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    res_valid <= 1'b0;
    res       <= '0;
    res.found <= 1'b1;
    res.kind  <= rch_pkg::KIND_ANSWER;
    res.last  <= 1'b1;
    res.buffer_sel <= half;
    unique case (state)
      S_IDLE: begin
        i  <= '0;
        pv <= 1'b0;
        if (cmd_valid) begin
          cur <= cmd;
          if (!cmd.is_insert) begin
            state <= S_SCAN_LK;
          end else if (fits_new) begin
            state <= S_INSERT;
          end else begin
            keep  <= '0;
            dst   <= '0;
            state <= S_SCAN_CP;
          end
        end
      end
      S_SCAN_LK: begin
        if (match) begin
          res_valid   <= 1'b1;
          res.ref_out <= cur.item.ref_req;
          res.addr    <= rdata.offset;
          state       <= S_IDLE;
        end else if (!pv && !more) begin
          res_valid   <= 1'b1;
          res.ref_out <= cur.item.ref_req;
          res.found   <= 1'b0;
          state       <= S_IDLE;
        end else begin
          pv   <= more;
          pidx <= i[rch_pkg::IDX_W-1:0];
          if (more) i <= i + 1'b1;
        end
      end
      S_SCAN_CP: begin
        if (pv && rdata.count != '0) begin
          res_valid      <= 1'b1;
          res.kind       <= rch_pkg::KIND_COPY;
          res.last       <= 1'b0;
          res.ref_out    <= rdata.eref;
          res.addr       <= dst;
          res.src_addr   <= rdata.offset;
          res.length     <= rdata.bytes;
          res.buffer_sel <= ~half;
          keep           <= keep + 1'b1;
          dst            <= dst + rdata.bytes;
        end
        if (!pv && !more) begin
          // flip halves and retry the insert
          used     <= keep;
          free_ofs <= dst;
          half     <= ~half;
          state    <= S_INSERT;
        end else begin
          pv   <= more;
          pidx <= i[rch_pkg::IDX_W-1:0];
          if (more) i <= i + 1'b1;
        end
      end
      S_INSERT: begin
        res_valid <= 1'b1;
        if (fits_cur) begin
          res.ref_out <= next_ref;
          res.addr    <= free_ofs;
          next_ref    <= (next_ref == '1) ? 32'd1 : next_ref + 32'd1;
          used        <= used + 1'b1;
          free_ofs    <= free_ofs + cur.item.size;
        end else begin
          res.found <= 1'b0;
        end
        state <= S_IDLE;
      end
      default: state <= S_IDLE;
    endcase
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      used      <= '0;
      free_ofs  <= '0;
      half      <= 1'b0;
      next_ref  <= 32'd1;
      pv        <= 1'b0;
      i         <= '0;
    end
  end
endmodule

>>> rtl/refcounted_compacting_heap_unit.sv
// Top level of the reference-counted compacting heap.
// Depends on rch_pkg, rch_front and rch_back.
//
// Usage: drive item and raise start; a request is taken at a clock edge
// where start is high and busy is low. Up to two requests queue in the
// front end while the back end works, so busy rises only when both
// queue slots are taken.
// Each request yields zero or more copy commands (kind 0), then one answer
// (kind 1, last 1). Every result sits on res for one cycle with res_valid
// high; the receiver must take it then.
// Work per request, once it reaches the back end:
//   insert that fits: goes straight to the insert and answers.
//   retrieve, add, drop: reads used entries in order; stops at the match.
//   insert with compaction: one copy command per live entry as the table
//   RAM is read, then the insert is retried in the new half.
// The table RAM is read one entry per cycle; the back end takes a new
// request only after it has answered the one before.
// Reset empties the table, selects half 0, restarts references at 1 and
// drops any queued request. The table contents need no clearing.
module refcounted_compacting_heap_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  rch_pkg::item_t   item,
  output logic             busy,
  output logic             res_valid,
  output rch_pkg::result_t res
);
  rch_pkg::cmd_t cmd;
  logic          cmd_valid;
  logic          pop;

  rch_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .item     (item),
    .busy     (busy),
    .cmd      (cmd),
    .cmd_valid(cmd_valid),
    .pop      (pop)
  );

  rch_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cmd_valid(cmd_valid),
    .pop      (pop),
    .res_valid(res_valid),
    .res      (res)
  );

  a_last_is_answer: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.last == (res.kind == rch_pkg::KIND_ANSWER)))
    else $error("last flag disagrees with result kind");

  a_copy_found: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind == rch_pkg::KIND_COPY) |-> res.found)
    else $error("copy command without found");

  a_pop_needs_cmd: assert property (@(posedge clk) disable iff (rst)
    pop |-> cmd_valid)
    else $error("back end popped an empty queue");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.found) |-> (res.addr == '0))
    else $error("failed answer carries an address");
endmodule

>>> sim/tb_refcounted_compacting_heap_unit.sv
// Self-checking testbench for refcounted_compacting_heap_unit.
// Drives directed then random requests, predicts every copy command and answer
// in a behavioral heap model; depends on rch_pkg and the RTL top level.
module tb_refcounted_compacting_heap_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_CYCLES = 5000;
  localparam int DRAIN_CYCLES    = 60;
  localparam int RANDOM_ITEMS    = 360;

  logic             clk;
  logic             rst;
  logic             start;
  rch_pkg::item_t   item;
  logic             busy;
  logic             res_valid;
  rch_pkg::result_t res;

  refcounted_compacting_heap_unit uut (
    .clk(clk), .rst(rst), .start(start), .item(item),
    .busy(busy), .res_valid(res_valid), .res(res)
  );

  // predictor state
  logic [31:0]               heap_ref   [rch_pkg::MAX_ENTRIES];
  logic [rch_pkg::OFS_W-1:0] heap_bytes [rch_pkg::MAX_ENTRIES];
  logic [rch_pkg::OFS_W-1:0] heap_ofs   [rch_pkg::MAX_ENTRIES];
  logic [rch_pkg::RC_W-1:0]  heap_cnt   [rch_pkg::MAX_ENTRIES];
  int                        heap_used;
  int                        heap_free;
  logic                      heap_half;
  logic [31:0]               heap_next;

  rch_pkg::result_t expected_results[$];
  rch_pkg::result_t pinned_answers[$];
  bit               pin_flags[$];
  bit               failed;
  int               idle_cycles;
  int               quiet_phase;

  typedef struct {
    rch_pkg::opcode_t op;
    int               size;
    logic [31:0]      rref;
    bit               pinned;
    rch_pkg::result_t answer;
  } stim_row_t;

  function automatic rch_pkg::result_t answer_of(logic [31:0] r, logic f,
                                                 logic [rch_pkg::OFS_W-1:0] a);
    rch_pkg::result_t x;
    x = '0;
    x.kind = rch_pkg::KIND_ANSWER;
    x.ref_out = r;
    x.found = f;
    x.addr = a;
    x.buffer_sel = heap_half;
    x.last = 1'b1;
    return x;
  endfunction

  function automatic bit heap_fits(int sz);
    return (rch_pkg::MEMORY_BYTES - heap_free >= sz) && (heap_used < rch_pkg::MAX_ENTRIES);
  endfunction

  task automatic compact_heap();
    int keep;
    int dst;
    rch_pkg::result_t c;
    keep = 0;
    dst = 0;
    for (int i = 0; i < heap_used; i++) begin
      if (heap_cnt[i] == 0) continue;
      c = '0;
      c.kind = rch_pkg::KIND_COPY;
      c.ref_out = heap_ref[i];
      c.found = 1'b1;
      c.addr = dst[rch_pkg::OFS_W-1:0];
      c.src_addr = heap_ofs[i];
      c.length = heap_bytes[i];
      c.buffer_sel = ~heap_half;
      expected_results.push_back(c);
      heap_ref[keep] = heap_ref[i];
      heap_bytes[keep] = heap_bytes[i];
      heap_cnt[keep] = heap_cnt[i];
      heap_ofs[keep] = dst[rch_pkg::OFS_W-1:0];
      dst += heap_bytes[i];
      keep++;
    end
    heap_used = keep;
    heap_free = dst;
    heap_half = ~heap_half;
  endtask

  task automatic predict_heap(rch_pkg::item_t it);
    int idx;
    logic [31:0] r;
    if (it.opcode == rch_pkg::OP_INSERT) begin
      if (!heap_fits(int'(it.size))) compact_heap();
      if (!heap_fits(int'(it.size))) begin
        expected_results.push_back(answer_of('0, 1'b0, '0));
        return;
      end
      r = heap_next;
      heap_next = (r == 32'hFFFF_FFFF) ? 32'd1 : r + 32'd1;
      heap_ref[heap_used] = r;
      heap_bytes[heap_used] = it.size;
      heap_ofs[heap_used] = heap_free[rch_pkg::OFS_W-1:0];
      heap_cnt[heap_used] = 16'd1;
      heap_used++;
      heap_free += int'(it.size);
      expected_results.push_back(answer_of(r, 1'b1, heap_ofs[heap_used-1]));
      return;
    end
    idx = -1;
    for (int i = 0; i < heap_used; i++)
      if (idx < 0 && heap_ref[i] == it.ref_req) idx = i;
    if (idx < 0) begin
      expected_results.push_back(answer_of(it.ref_req, 1'b0, '0));
      return;
    end
    if (it.opcode == rch_pkg::OP_ADD && heap_cnt[idx] != 16'hFFFF) heap_cnt[idx]++;
    else if (it.opcode == rch_pkg::OP_DROP && heap_cnt[idx] != 0) heap_cnt[idx]--;
    expected_results.push_back(answer_of(it.ref_req, 1'b1, heap_ofs[idx]));
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // check results
  always @(posedge clk) begin
    rch_pkg::result_t want;
    rch_pkg::result_t pin;
    bit is_pinned;
    if (!rst && res_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, res);
        failed = 1'b1;
      end else begin
        want = expected_results.pop_front();
        if (res !== want) begin
          $display("%0t: mismatch expected %p actual %p", $time, want, res);
          failed = 1'b1;
        end
        if (want.last) begin
          is_pinned = 1'b0;
          if (pin_flags.size() != 0) is_pinned = pin_flags.pop_front();
          if (is_pinned && pinned_answers.size() != 0) begin
            pin = pinned_answers.pop_front();
            if (res !== pin) begin
              $display("%0t: table mismatch expected %p actual %p", $time, pin, res);
              failed = 1'b1;
            end
          end
        end
      end
    end
  end

  // watchdog: cycles without an accepted transaction or a result
  always @(posedge clk) begin
    if (rst || (start && !busy) || res_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("refcounted_compacting_heap_unit test failed");
      $finish;
    end
  end

  function automatic logic [31:0] pick_ref();
    int u;
    u = $urandom_range(0, 99);
    if (u < 70 && heap_used > 0) return heap_ref[$urandom_range(0, heap_used - 1)];
    if (u < 80) return heap_next - 32'd1 - $urandom_range(0, 40);
    if (u < 85) return '0;
    return $urandom();
  endfunction

  function automatic int pick_size();
    int u;
    u = $urandom_range(0, 99);
    if (u < 70) return $urandom_range(0, 4095);
    if (u < 85) return $urandom_range(4096, 20000);
    if (u < 92) return 65536;
    if (u < 96) return 0;
    return $urandom_range(65537, 131071);
  endfunction

  // one transaction; the predictor runs at the accepting edge
  task automatic send_item(rch_pkg::item_t it, bit pinned, rch_pkg::result_t ans);
    if (quiet_phase == 0) begin
      while ($urandom_range(0, 99) < 18) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_heap(it);
    pin_flags.push_back(pinned);
    if (pinned) pinned_answers.push_back(ans);
  endtask

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    rch_pkg::item_t it;
    rch_pkg::result_t none;
    int n;
    failed = 1'b0;
    idle_cycles = 0;
    quiet_phase = 0;
    heap_used = 0;
    heap_free = 0;
    heap_half = 1'b0;
    heap_next = 32'd1;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    none = '0;

    // directed table; pinned answers are read straight off the spec
    rows.push_back('{rch_pkg::OP_RETRIEVE, 0, 32'd0, 1,
      '{kind: rch_pkg::KIND_ANSWER, last: 1, default: 0}});
    rows.push_back('{rch_pkg::OP_DROP, 0, 32'hFFFF_FFFF, 1,
      '{kind: rch_pkg::KIND_ANSWER, ref_out: 32'hFFFF_FFFF, last: 1, default: 0}});
    rows.push_back('{rch_pkg::OP_INSERT, 0, 32'd0, 1,
      '{kind: rch_pkg::KIND_ANSWER, ref_out: 32'd1, found: 1, last: 1, default: 0}});
    rows.push_back('{rch_pkg::OP_INSERT, 100, 32'd0, 0, none});
    rows.push_back('{rch_pkg::OP_RETRIEVE, 0, 32'd2, 0, none});
    rows.push_back('{rch_pkg::OP_ADD, 0, 32'd2, 0, none});
    rows.push_back('{rch_pkg::OP_DROP, 0, 32'd2, 0, none});
    rows.push_back('{rch_pkg::OP_DROP, 0, 32'd2, 0, none});
    rows.push_back('{rch_pkg::OP_DROP, 0, 32'd2, 0, none});
    rows.push_back('{rch_pkg::OP_INSERT, 65536, 32'd0, 0, none});
    rows.push_back('{rch_pkg::OP_INSERT, 131071, 32'd0, 0, none});
    rows.push_back('{rch_pkg::OP_INSERT, 65537, 32'd0, 0, none});
    rows.push_back('{rch_pkg::OP_RETRIEVE, 0, 32'd1, 0, none});
    rows.push_back('{rch_pkg::OP_INSERT, 65535, 32'd0, 0, none});
    rows.push_back('{rch_pkg::OP_INSERT, 1, 32'd0, 0, none});
    rows.push_back('{rch_pkg::OP_ADD, 0, 32'h5555_AAAA, 0, none});
    for (int i = 0; i < rows.size(); i++) begin
      row = rows[i];
      it.opcode = row.op;
      it.size = row.size[rch_pkg::OFS_W-1:0];
      it.ref_req = row.rref;
      send_item(it, row.pinned, row.answer);
    end

    // fill the table with zero-byte inserts, then force a compaction by count
    for (int i = 0; i < rch_pkg::MAX_ENTRIES + 2; i++) begin
      it = '{opcode: rch_pkg::OP_INSERT, size: '0, ref_req: '0};
      send_item(it, 0, none);
    end

    // raise one count three times
    if (heap_used > 0) begin
      n = 0;
      while (n < 3) begin
        it = '{opcode: rch_pkg::OP_ADD, size: rch_pkg::OFS_W'($urandom()),
               ref_req: heap_ref[0]};
        send_item(it, 0, none);
        n++;
      end
    end

    // random: mostly lookups of live references mixed with inserts
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet_phase = (i >= 150 && i < 230) ? 1 : 0;
      it.opcode = rch_pkg::opcode_t'($urandom_range(0, 3));
      if ($urandom_range(0, 99) < 35) it.opcode = rch_pkg::OP_DROP;
      it.size = rch_pkg::OFS_W'(pick_size());
      it.ref_req = pick_ref();
      if (it.opcode == rch_pkg::OP_INSERT && $urandom_range(0, 9) == 0)
        it.size[rch_pkg::OFS_W-1] = 1'b1;
      send_item(it, 0, none);
    end
    start <= 1'b0;

    n = 0;
    while (expected_results.size() != 0 && n < WATCHDOG_CYCLES) begin
      @(posedge clk);
      n++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed && expected_results.size() == 0) begin
      $display("refcounted_compacting_heap_unit test passed");
    end else begin
      $display("refcounted_compacting_heap_unit test failed");
    end
    $finish;
  end
endmodule
